// File: src/srs_pkg.sv
// shared types, constants and codes for the stochastic reaction step block
`default_nettype none
package srs_pkg;

    // defaults for the top-level parameters
    localparam int COUNT_BITS_DEF     = 24;
    localparam int TIME_FRAC_BITS_DEF = 32;

    // fixed field widths
    localparam int LIMB_BITS  = 32;
    localparam int LIMBS      = 5;
    localparam int WIDE_BITS  = LIMB_BITS * LIMBS;
    localparam int RATE_BITS  = 62;
    localparam int C_FRAC     = 24;
    localparam int C_BITS     = 40;
    localparam int K_BITS     = 32;
    localparam int INIT_BITS  = 24;
    localparam int TIME_BITS  = 64;
    localparam int DIV_BITS   = 64;
    localparam int NL2_BITS   = 38;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;

    // sequencer step counts
    localparam int SCALE_STEPS = LIMBS;
    localparam int LOG_STEPS   = 32;
    localparam int CNT_W       = $clog2(LOG_STEPS);

    localparam logic [LIMB_BITS-1:0] LN2_Q32  = 32'hB172_17F8;
    localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_A  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_B  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_C  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_D  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_X1 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_X2 = 3'd5;

    // reaction codes
    localparam logic [1:0] REAC_X1_UP   = 2'd0;
    localparam logic [1:0] REAC_X1_DOWN = 2'd1;
    localparam logic [1:0] REAC_X2_UP   = 2'd2;
    localparam logic [1:0] REAC_X2_DOWN = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_LD_C,
        OP_LD_BD,
        OP_LD_B,
        OP_LD_TOT,
        OP_SCALE,
        OP_SAV_R3,
        OP_SAV_R1,
        OP_SAV_R2,
        OP_SUMS,
        OP_PICK,
        OP_LOG_INIT,
        OP_LOG_SQ,
        OP_LN_NL2,
        OP_LN_HI,
        OP_LN_LO,
        OP_LN_SUM,
        OP_DIV_START,
        OP_COMMIT_STEP,
        OP_COMMIT_ZERO,
        OP_COMMIT_RST
    } t_op;

    typedef enum logic [1:0] {
        SEL_X1,
        SEL_X2,
        SEL_UPICK
    } t_msel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CUBE1,
        S_CUBE2,
        S_CUBE3,
        S_SAV_R3,
        S_LD_BD,
        S_MUL_BD,
        S_SAV_R1,
        S_LD_B,
        S_MUL_B,
        S_SAV_R2,
        S_SUMS,
        S_LD_TOT,
        S_MUL_TOT,
        S_PICK,
        S_LOG_INIT,
        S_LOG_SQ,
        S_LN_NL2,
        S_LN_HI,
        S_LN_LO,
        S_LN_SUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_FIN_STEP,
        S_FIN_ZERO,
        S_FIN_RST
    } t_state;

    typedef struct packed {
        t_op   op;
        t_msel sel;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic total_zero;
        logic div_busy;
    } t_status;

endpackage
`default_nettype wire

// File: src/srs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module srs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [srs_pkg::DIV_BITS-1:0]  i_dividend,
    input  wire logic [srs_pkg::DIV_BITS-1:0]  i_divisor,
    output logic                               o_busy,
    output logic [srs_pkg::DIV_BITS-1:0]       o_quotient
);
    localparam int W  = srs_pkg::DIV_BITS;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_div;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;
    logic          w_fit;

    always_comb begin
        w_shift = {r_rem, r_quo[W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_fit   = (w_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// File: src/srs_ctrl.sv
// sequencer for the reaction step datapath
`default_nettype none
module srs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_m_tready,
    input  wire srs_pkg::t_status i_status,
    output srs_pkg::t_cmd        o_cmd,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid
);
    localparam int CW = srs_pkg::CNT_W;

    srs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_m_valid, n_m_valid;
    logic            w_scale_last;
    logic            w_log_last;
    logic            w_out_free;
    logic            w_commit;

    assign w_scale_last = (r_cnt == CW'(srs_pkg::SCALE_STEPS - 1));
    assign w_log_last   = (r_cnt == CW'(srs_pkg::LOG_STEPS - 1));
    assign w_out_free   = !r_m_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srs_pkg::S_IDLE:      if (i_s_tvalid) n_state = srs_pkg::S_DECODE;
            srs_pkg::S_DECODE: begin
                n_state = i_status.restart ? srs_pkg::S_FIN_RST : srs_pkg::S_CUBE1;
            end
            srs_pkg::S_CUBE1:     if (w_scale_last) n_state = srs_pkg::S_CUBE2;
            srs_pkg::S_CUBE2:     if (w_scale_last) n_state = srs_pkg::S_CUBE3;
            srs_pkg::S_CUBE3:     if (w_scale_last) n_state = srs_pkg::S_SAV_R3;
            srs_pkg::S_SAV_R3:    n_state = srs_pkg::S_LD_BD;
            srs_pkg::S_LD_BD:     n_state = srs_pkg::S_MUL_BD;
            srs_pkg::S_MUL_BD:    if (w_scale_last) n_state = srs_pkg::S_SAV_R1;
            srs_pkg::S_SAV_R1:    n_state = srs_pkg::S_LD_B;
            srs_pkg::S_LD_B:      n_state = srs_pkg::S_MUL_B;
            srs_pkg::S_MUL_B:     if (w_scale_last) n_state = srs_pkg::S_SAV_R2;
            srs_pkg::S_SAV_R2:    n_state = srs_pkg::S_SUMS;
            srs_pkg::S_SUMS:      n_state = srs_pkg::S_LD_TOT;
            srs_pkg::S_LD_TOT: begin
                n_state = i_status.total_zero ? srs_pkg::S_FIN_ZERO : srs_pkg::S_MUL_TOT;
            end
            srs_pkg::S_MUL_TOT:   if (w_scale_last) n_state = srs_pkg::S_PICK;
            srs_pkg::S_PICK:      n_state = srs_pkg::S_LOG_INIT;
            srs_pkg::S_LOG_INIT:  n_state = srs_pkg::S_LOG_SQ;
            srs_pkg::S_LOG_SQ:    if (w_log_last) n_state = srs_pkg::S_LN_NL2;
            srs_pkg::S_LN_NL2:    n_state = srs_pkg::S_LN_HI;
            srs_pkg::S_LN_HI:     n_state = srs_pkg::S_LN_LO;
            srs_pkg::S_LN_LO:     n_state = srs_pkg::S_LN_SUM;
            srs_pkg::S_LN_SUM:    n_state = srs_pkg::S_DIV_START;
            srs_pkg::S_DIV_START: n_state = srs_pkg::S_DIV_WAIT;
            srs_pkg::S_DIV_WAIT:  if (!i_status.div_busy) n_state = srs_pkg::S_FIN_STEP;
            srs_pkg::S_FIN_STEP,
            srs_pkg::S_FIN_ZERO,
            srs_pkg::S_FIN_RST:   if (w_out_free) n_state = srs_pkg::S_IDLE;
            default:              n_state = srs_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op  = srs_pkg::OP_NOP;
        o_cmd.sel = srs_pkg::SEL_X1;
        case (r_state)
            srs_pkg::S_IDLE:      if (i_s_tvalid) o_cmd.op = srs_pkg::OP_CAPTURE;
            srs_pkg::S_DECODE:    o_cmd.op = srs_pkg::OP_LD_C;
            srs_pkg::S_CUBE1,
            srs_pkg::S_CUBE2,
            srs_pkg::S_MUL_BD,
            srs_pkg::S_MUL_B:     o_cmd.op = srs_pkg::OP_SCALE;
            srs_pkg::S_CUBE3: begin
                o_cmd.op  = srs_pkg::OP_SCALE;
                o_cmd.sel = srs_pkg::SEL_X2;
            end
            srs_pkg::S_MUL_TOT: begin
                o_cmd.op  = srs_pkg::OP_SCALE;
                o_cmd.sel = srs_pkg::SEL_UPICK;
            end
            srs_pkg::S_SAV_R3:    o_cmd.op = srs_pkg::OP_SAV_R3;
            srs_pkg::S_LD_BD:     o_cmd.op = srs_pkg::OP_LD_BD;
            srs_pkg::S_SAV_R1:    o_cmd.op = srs_pkg::OP_SAV_R1;
            srs_pkg::S_LD_B:      o_cmd.op = srs_pkg::OP_LD_B;
            srs_pkg::S_SAV_R2:    o_cmd.op = srs_pkg::OP_SAV_R2;
            srs_pkg::S_SUMS:      o_cmd.op = srs_pkg::OP_SUMS;
            srs_pkg::S_LD_TOT:    o_cmd.op = srs_pkg::OP_LD_TOT;
            srs_pkg::S_PICK:      o_cmd.op = srs_pkg::OP_PICK;
            srs_pkg::S_LOG_INIT:  o_cmd.op = srs_pkg::OP_LOG_INIT;
            srs_pkg::S_LOG_SQ:    o_cmd.op = srs_pkg::OP_LOG_SQ;
            srs_pkg::S_LN_NL2:    o_cmd.op = srs_pkg::OP_LN_NL2;
            srs_pkg::S_LN_HI:     o_cmd.op = srs_pkg::OP_LN_HI;
            srs_pkg::S_LN_LO:     o_cmd.op = srs_pkg::OP_LN_LO;
            srs_pkg::S_LN_SUM:    o_cmd.op = srs_pkg::OP_LN_SUM;
            srs_pkg::S_DIV_START: o_cmd.op = srs_pkg::OP_DIV_START;
            srs_pkg::S_FIN_STEP:  if (w_out_free) o_cmd.op = srs_pkg::OP_COMMIT_STEP;
            srs_pkg::S_FIN_ZERO:  if (w_out_free) o_cmd.op = srs_pkg::OP_COMMIT_ZERO;
            srs_pkg::S_FIN_RST:   if (w_out_free) o_cmd.op = srs_pkg::OP_COMMIT_RST;
            default:              o_cmd.op = srs_pkg::OP_NOP;
        endcase
    end

    assign w_commit = (o_cmd.op == srs_pkg::OP_COMMIT_STEP)
                   || (o_cmd.op == srs_pkg::OP_COMMIT_ZERO)
                   || (o_cmd.op == srs_pkg::OP_COMMIT_RST);

    // step counter for multi-cycle passes
    always_comb begin
        n_cnt = '0;
        if (o_cmd.op == srs_pkg::OP_SCALE) begin
            n_cnt = w_scale_last ? '0 : r_cnt + 1'b1;
        end else if (o_cmd.op == srs_pkg::OP_LOG_SQ) begin
            n_cnt = w_log_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_commit) begin
            n_m_valid = 1'b1;
        end else if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srs_pkg::S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == srs_pkg::S_IDLE);
    assign o_m_tvalid = r_m_valid;
endmodule
`default_nettype wire

// File: src/srs_dpath.sv
// datapath: rates, reaction pick, log, divide and count update
`default_nettype none
module srs_dpath #(
    parameter int COUNT_BITS     = srs_pkg::COUNT_BITS_DEF,
    parameter int TIME_FRAC_BITS = srs_pkg::TIME_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire srs_pkg::t_cmd                   i_cmd,
    output srs_pkg::t_status                     o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [srs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_opcode,
    input  wire logic [31:0]                     i_u_wait,
    input  wire logic [31:0]                     i_u_pick,
    output logic [COUNT_BITS-1:0]                o_x1,
    output logic [COUNT_BITS-1:0]                o_x2,
    output logic [srs_pkg::TIME_BITS-1:0]        o_time,
    output logic [1:0]                           o_reac,
    output logic                                 o_zero
);
    localparam int LB         = srs_pkg::LIMB_BITS;
    localparam int NL         = srs_pkg::LIMBS;
    localparam int WB         = srs_pkg::WIDE_BITS;
    localparam int RB         = srs_pkg::RATE_BITS;
    localparam int CF         = srs_pkg::C_FRAC;
    localparam int TB         = srs_pkg::TIME_BITS;
    localparam int NB         = srs_pkg::NL2_BITS;
    localparam int LN_SHIFT   = TIME_FRAC_BITS - 16;
    localparam int DIV_W_BITS = srs_pkg::DIV_BITS;

    // configuration
    logic [srs_pkg::K_BITS-1:0]    r_rate_a, r_rate_b, r_rate_d;
    logic [srs_pkg::C_BITS-1:0]    r_rate_c;
    logic [srs_pkg::INIT_BITS-1:0] r_init_x1, r_init_x2;

    // state
    logic [COUNT_BITS-1:0] r_x1, r_x2;
    logic [TB-1:0]         r_time;
    logic [1:0]            r_reac;
    logic                  r_zero;

    // captured item
    logic        r_opcode;
    logic [31:0] r_u_wait, r_u_pick;

    // limb scaler
    logic [LB-1:0] r_v [NL];
    logic [LB-1:0] r_carry;
    logic [WB-1:0] w_vw;

    // rates and prefix sums
    logic [RB-1:0] r_s0, r_r3;
    logic [TB-1:0] r_s1, r_s2, r_s3;
    logic [1:0]    r_pick;

    // log unit
    logic [LB-1:0] r_m, r_frac;
    logic [5:0]    r_int;
    logic [NB-1:0] r_nl2;
    logic [63:0]   r_ln_hi, r_lnq;
    logic [LB-1:0] r_ln_lo;
    logic [4:0]    w_lead;

    // shared multiplier
    logic [LB-1:0] w_ma, w_mb, w_sop;
    logic [63:0]   w_prod, w_acc;
    logic [32:0]   w_sq;

    logic [RB-1:0] w_r3_sat, w_r0, w_lin;
    logic [RB:0]   w_r0_sum;
    logic [32:0]   w_bd;
    logic [95:0]   w_pp;
    logic [3:0]    w_above;
    logic [TB:0]   w_tsum;
    logic [DIV_W_BITS-1:0] w_quo;
    logic          w_div_busy;
    logic [31:0]   w_ix1, w_ix2;

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_vw[k*LB +: LB] = r_v[k];
        end
    end

    always_comb begin
        case (i_cmd.sel)
            srs_pkg::SEL_X1:    w_sop = LB'(r_x1);
            srs_pkg::SEL_X2:    w_sop = LB'(r_x2);
            srs_pkg::SEL_UPICK: w_sop = r_u_pick;
            default:            w_sop = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            srs_pkg::OP_SCALE: begin
                w_ma = r_v[0];
                w_mb = w_sop;
            end
            srs_pkg::OP_LOG_SQ: begin
                w_ma = r_m;
                w_mb = r_m;
            end
            srs_pkg::OP_LN_HI: begin
                w_ma = LB'(r_nl2[NB-1:LB]);
                w_mb = srs_pkg::LN2_Q32;
            end
            srs_pkg::OP_LN_LO: begin
                w_ma = r_nl2[LB-1:0];
                w_mb = srs_pkg::LN2_Q32;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = 64'(w_ma) * 64'(w_mb);
        w_acc  = w_prod + 64'(r_carry);
        w_sq   = w_prod[63:31];
    end

    // leading one of the wait fraction
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_u_wait[i]) w_lead = 5'(i);
        end
    end

    // saturated rates from the scaler word
    always_comb begin
        w_r3_sat = (w_vw[WB-1:CF+RB] != '0) ? srs_pkg::RATE_MAX : w_vw[CF +: RB];
        w_r0_sum = {1'b0, w_r3_sat} + (RB+1)'(r_rate_a);
        w_r0     = w_r0_sum[RB] ? srs_pkg::RATE_MAX : w_r0_sum[RB-1:0];
        w_lin    = (w_vw[WB-1:RB] != '0) ? srs_pkg::RATE_MAX : w_vw[RB-1:0];
        w_bd     = {1'b0, r_rate_b} + {1'b0, r_rate_d};
    end

    // exact compare of prefix * 2^32 against u_pick * total
    always_comb begin
        w_pp       = w_vw[95:0];
        w_above[0] = {2'b0, r_s0, 32'b0} > w_pp;
        w_above[1] = {r_s1, 32'b0} > w_pp;
        w_above[2] = {r_s2, 32'b0} > w_pp;
        w_above[3] = {r_s3, 32'b0} > w_pp;
    end

    assign w_tsum = {1'b0, r_time} + {1'b0, w_quo};
    assign w_ix1  = 32'(r_init_x1);
    assign w_ix2  = 32'(r_init_x2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_a  <= '0;
            r_rate_b  <= '0;
            r_rate_c  <= '0;
            r_rate_d  <= '0;
            r_init_x1 <= '0;
            r_init_x2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                srs_pkg::CFG_RATE_A:  r_rate_a  <= i_cfg_data[srs_pkg::K_BITS-1:0];
                srs_pkg::CFG_RATE_B:  r_rate_b  <= i_cfg_data[srs_pkg::K_BITS-1:0];
                srs_pkg::CFG_RATE_C:  r_rate_c  <= i_cfg_data[srs_pkg::C_BITS-1:0];
                srs_pkg::CFG_RATE_D:  r_rate_d  <= i_cfg_data[srs_pkg::K_BITS-1:0];
                srs_pkg::CFG_INIT_X1: r_init_x1 <= i_cfg_data[srs_pkg::INIT_BITS-1:0];
                srs_pkg::CFG_INIT_X2: r_init_x2 <= i_cfg_data[srs_pkg::INIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // counts and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1   <= '0;
            r_x2   <= '0;
            r_time <= '0;
            r_reac <= srs_pkg::REAC_X1_UP;
            r_zero <= 1'b0;
        end else begin
            case (i_cmd.op)
                srs_pkg::OP_COMMIT_STEP: begin
                    r_time <= w_tsum[TB] ? '1 : w_tsum[TB-1:0];
                    r_reac <= r_pick;
                    r_zero <= 1'b0;
                    case (r_pick)
                        srs_pkg::REAC_X1_UP:   if (r_x1 != '1) r_x1 <= r_x1 + 1'b1;
                        srs_pkg::REAC_X1_DOWN: if (r_x1 != '0) r_x1 <= r_x1 - 1'b1;
                        srs_pkg::REAC_X2_UP:   if (r_x2 != '1) r_x2 <= r_x2 + 1'b1;
                        default:               if (r_x2 != '0) r_x2 <= r_x2 - 1'b1;
                    endcase
                end
                srs_pkg::OP_COMMIT_ZERO: begin
                    r_reac <= srs_pkg::REAC_X1_UP;
                    r_zero <= 1'b1;
                end
                srs_pkg::OP_COMMIT_RST: begin
                    r_x1   <= w_ix1[COUNT_BITS-1:0];
                    r_x2   <= w_ix2[COUNT_BITS-1:0];
                    r_time <= '0;
                    r_reac <= srs_pkg::REAC_X1_UP;
                    r_zero <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            srs_pkg::OP_CAPTURE: begin
                r_opcode <= i_opcode;
                r_u_wait <= (i_u_wait == '0) ? 32'd1 : i_u_wait;
                r_u_pick <= i_u_pick;
            end
            srs_pkg::OP_LD_C: begin
                r_v[0]  <= r_rate_c[LB-1:0];
                r_v[1]  <= LB'(r_rate_c[srs_pkg::C_BITS-1:LB]);
                for (int k = 2; k < NL; k++) r_v[k] <= '0;
                r_carry <= '0;
            end
            srs_pkg::OP_LD_BD: begin
                r_v[0]  <= w_bd[LB-1:0];
                r_v[1]  <= LB'(w_bd[32]);
                for (int k = 2; k < NL; k++) r_v[k] <= '0;
                r_carry <= '0;
            end
            srs_pkg::OP_LD_B: begin
                r_v[0]  <= r_rate_b;
                for (int k = 1; k < NL; k++) r_v[k] <= '0;
                r_carry <= '0;
            end
            srs_pkg::OP_LD_TOT: begin
                r_v[0]  <= r_s3[LB-1:0];
                r_v[1]  <= r_s3[TB-1:LB];
                for (int k = 2; k < NL; k++) r_v[k] <= '0;
                r_carry <= '0;
            end
            srs_pkg::OP_SCALE: begin
                // limbs rotate through the multiplier, least significant first
                for (int k = 0; k < NL - 1; k++) r_v[k] <= r_v[k+1];
                r_v[NL-1] <= w_acc[LB-1:0];
                r_carry   <= w_acc[63:LB];
            end
            srs_pkg::OP_SAV_R3: begin
                r_r3    <= w_r3_sat;
                r_s0    <= w_r0;
                r_carry <= '0;
            end
            srs_pkg::OP_SAV_R1: r_s1 <= TB'(r_s0) + TB'(w_lin);
            srs_pkg::OP_SAV_R2: r_s2 <= r_s1 + TB'(w_lin);
            srs_pkg::OP_SUMS:   r_s3 <= r_s2 + TB'(r_r3);
            srs_pkg::OP_PICK: begin
                if (w_above[0])      r_pick <= srs_pkg::REAC_X1_UP;
                else if (w_above[1]) r_pick <= srs_pkg::REAC_X1_DOWN;
                else if (w_above[2]) r_pick <= srs_pkg::REAC_X2_UP;
                else if (w_above[3]) r_pick <= srs_pkg::REAC_X2_DOWN;
                else                 r_pick <= srs_pkg::REAC_X1_UP;
            end
            srs_pkg::OP_LOG_INIT: begin
                r_m    <= r_u_wait << (5'd31 - w_lead);
                r_int  <= 6'd32 - 6'(w_lead);
                r_frac <= '0;
            end
            srs_pkg::OP_LOG_SQ: begin
                // square the mantissa, one fraction bit of log2 per pass
                if (w_sq[32]) begin
                    r_m    <= w_sq[32:1];
                    r_frac <= {r_frac[LB-2:0], 1'b1};
                end else begin
                    r_m    <= w_sq[31:0];
                    r_frac <= {r_frac[LB-2:0], 1'b0};
                end
            end
            srs_pkg::OP_LN_NL2: r_nl2   <= {r_int, 32'b0} - NB'(r_frac);
            srs_pkg::OP_LN_HI:  r_ln_hi <= w_prod;
            srs_pkg::OP_LN_LO:  r_ln_lo <= w_prod[63:LB];
            srs_pkg::OP_LN_SUM: r_lnq   <= r_ln_hi + 64'(r_ln_lo);
            default: ;
        endcase
    end

    srs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == srs_pkg::OP_DIV_START),
        .i_dividend (r_lnq << LN_SHIFT),
        .i_divisor  (r_s3),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign o_status.restart    = r_opcode;
    assign o_status.total_zero = (r_s3 == '0);
    assign o_status.div_busy   = w_div_busy;

    assign o_x1   = r_x1;
    assign o_x2   = r_x2;
    assign o_time = r_time;
    assign o_reac = r_reac;
    assign o_zero = r_zero;
endmodule
`default_nettype wire

// File: src/stochastic_reaction_step.sv
// top level of the stochastic reaction step block
`default_nettype none
// One step of a direct-method stochastic simulation for two species. Each
// input transfer carries an opcode in tuser (0 step, 1 restart) and two Q0.32
// fractions in tdata; each one yields exactly one output transfer with both
// counts, the Q32.32 elapsed time, the reaction fired and a zero-rate flag.
// Items are handled one at a time. A step result passes through decode, the
// cubic rate (three passes on a shared 32x32 multiplier that walks five
// 32-bit limbs), the linear rates, the sums and the pick product, the log
// (one squaring pass per fraction bit), the bit-serial divide and the commit.
// The next input transfer can be taken once the result is committed. A zero
// total rate skips the pick, log and divide; a restart goes from decode
// straight to its commit. A finished result waits in the output register
// while the next item is already taken in; a stalled output holds back the
// next commit.
// Configuration writes go through a plain write port
// (index 0..5: rate_a, rate_b, rate_c, rate_d, init_x1, init_x2) and are
// expected only while the block is idle.
module stochastic_reaction_step #(
    parameter int COUNT_BITS     = srs_pkg::COUNT_BITS_DEF,
    parameter int TIME_FRAC_BITS = srs_pkg::TIME_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [srs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [63:0]                     i_s_tdata,  // u_wait, u_pick
    input  wire logic                            i_s_tuser,  // opcode
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // count_x1, count_x2, elapsed_time, reaction
    output logic [((2*COUNT_BITS+srs_pkg::TIME_BITS+2+7)/8)*8-1:0] o_m_tdata,
    output logic                                 o_m_tuser   // rate_zero
);
    localparam int OUT_W  = 2*COUNT_BITS + srs_pkg::TIME_BITS + 2;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    srs_pkg::t_cmd    w_cmd;
    srs_pkg::t_status w_status;
    logic [COUNT_BITS-1:0]         w_x1, w_x2;
    logic [srs_pkg::TIME_BITS-1:0] w_time;
    logic [1:0]                    w_reac;
    logic                          w_zero;

    // sequencer: owns both handshakes and the step order
    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    // arithmetic, registers and the simulation state
    srs_dpath #(
        .COUNT_BITS     (COUNT_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_s_tuser),
        .i_u_wait   (i_s_tdata[31:0]),
        .i_u_pick   (i_s_tdata[63:32]),
        .o_x1       (w_x1),
        .o_x2       (w_x2),
        .o_time     (w_time),
        .o_reac     (w_reac),
        .o_zero     (w_zero)
    );

    // the state registers are the result payload; they change only on commit
    assign o_m_tdata = OUT_TW'({w_reac, w_time, w_x2, w_x1});
    assign o_m_tuser = w_zero;

    // one item in flight: after a transfer in, no second one is taken at once
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    // a zero-rate result always names reaction zero
    a_zero_reac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (w_reac == srs_pkg::REAC_X1_UP))
        else $error("zero-rate result with a nonzero reaction");

    // no commit may overwrite a result that is still held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |->
            (w_cmd.op != srs_pkg::OP_COMMIT_STEP && w_cmd.op != srs_pkg::OP_COMMIT_ZERO
             && w_cmd.op != srs_pkg::OP_COMMIT_RST))
        else $error("commit while the output is stalled");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the stochastic reaction step block
`timescale 1ns / 1ps
module tb_top;

    localparam int OUT_W = ((2*24+srs_pkg::TIME_BITS+2+7)/8)*8;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [srs_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [63:0]                    i_s_tdata;   // u_wait, u_pick
    logic                           i_s_tuser;   // opcode
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [OUT_W-1:0]               o_m_tdata;   // count_x1, count_x2, elapsed_time, reaction
    logic                           o_m_tuser;   // rate_zero

    stochastic_reaction_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    localparam logic OPC_STEP    = 1'b0;
    localparam logic OPC_RESTART = 1'b1;
    localparam logic [63:0] RATE_SAT = {2'b00, srs_pkg::RATE_MAX};
    localparam logic [23:0] COUNT_TOP = 24'hFF_FFFF;

    typedef struct packed {
        logic [23:0] x1;
        logic [23:0] x2;
        logic [63:0] elapsed;
        logic [1:0]  reac;
        logic        zero;
    } t_step_result;

    // mirror of the block's registers and state
    logic [31:0] mdl_a, mdl_b, mdl_d;
    logic [39:0] mdl_c;
    logic [23:0] mdl_init1, mdl_init2;
    logic [23:0] mdl_x1, mdl_x2;
    logic [63:0] mdl_time;

    t_step_result pending_results[$];
    int  errors;
    bit  idle_free;      // when set, neither side inserts gaps
    int  burst_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("Test completed with failures");
        $finish;
    end

    // -ln(u / 2^32) in Q.32 via leading one plus repeated squaring
    function automatic logic [63:0] neg_ln_q32(logic [31:0] u);
        int e;
        logic [63:0] m, frac, nl2;
        e = 31;
        while (e > 0 && !u[e]) e--;
        m = (64'(u) << (31 - e)) & 64'hFFFF_FFFF;
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        nl2 = (64'(32 - e) << 32) - frac;
        return (nl2 >> 32) * 64'(srs_pkg::LN2_Q32)
             + (((nl2 & 64'hFFFF_FFFF) * 64'(srs_pkg::LN2_Q32)) >> 32);
    endfunction

    function automatic logic [63:0] clamp_rate(logic [159:0] v);
        return (v > 160'(RATE_SAT)) ? RATE_SAT : v[63:0];
    endfunction

    // advance the mirrored state by one accepted item
    function automatic t_step_result predict_step(logic opc, logic [31:0] uw, logic [31:0] up);
        t_step_result res;
        logic [159:0] cube;
        logic [63:0]  r[4];
        logic [63:0]  total, prefix, dt;
        logic [1:0]   pick;
        pick = srs_pkg::REAC_X1_UP;
        res.zero = 1'b0;
        if (opc == OPC_RESTART) begin
            mdl_x1 = mdl_init1;
            mdl_x2 = mdl_init2;
            mdl_time = '0;
        end else begin
            if (uw == 32'd0) uw = 32'd1;
            cube = 160'(mdl_c) * 160'(mdl_x1) * 160'(mdl_x1) * 160'(mdl_x2);
            r[3] = clamp_rate(cube >> 24);
            r[0] = clamp_rate(160'(mdl_a) + 160'(r[3]));
            r[1] = clamp_rate((160'(mdl_b) + 160'(mdl_d)) * 160'(mdl_x1));
            r[2] = clamp_rate(160'(mdl_b) * 160'(mdl_x1));
            total = r[0] + r[1] + r[2] + r[3];
            if (total == 64'd0) begin
                res.zero = 1'b1;
            end else begin
                prefix = '0;
                for (int j = 3; j >= 0; j--) begin
                    // walk top-down so the first qualifying prefix wins
                    prefix = '0;
                    for (int k = 0; k <= j; k++) prefix += r[k];
                    if ((128'(prefix) << 32) > 128'(up) * 128'(total)) pick = 2'(j);
                end
                dt = (neg_ln_q32(uw) << 16) / total;
                mdl_time = (mdl_time > ~dt) ? '1 : mdl_time + dt;
                case (pick)
                    srs_pkg::REAC_X1_UP:   if (mdl_x1 != COUNT_TOP) mdl_x1++;
                    srs_pkg::REAC_X1_DOWN: if (mdl_x1 != 24'd0) mdl_x1--;
                    srs_pkg::REAC_X2_UP:   if (mdl_x2 != COUNT_TOP) mdl_x2++;
                    default:               if (mdl_x2 != 24'd0) mdl_x2--;
                endcase
            end
        end
        res.x1 = mdl_x1;
        res.x2 = mdl_x2;
        res.elapsed = mdl_time;
        res.reac = pick;
        return res;
    endfunction

    // one transfer on the input stream, with bursty gaps between items
    task automatic send_item(logic opc, logic [31:0] uw, logic [31:0] up);
        int gap;
        t_step_result exp_res;
        gap = 0;
        if (!idle_free) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(0, 12);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= opc;
        i_s_tdata  <= {up, uw};
        do @(posedge i_clk); while (!o_s_tready);
        exp_res = predict_step(opc, uw, up);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    // registers change only with the block idle
    task automatic write_reg(logic [srs_pkg::CFG_ADDR_W-1:0] idx,
                             logic [srs_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            srs_pkg::CFG_RATE_A:  mdl_a = val[31:0];
            srs_pkg::CFG_RATE_B:  mdl_b = val[31:0];
            srs_pkg::CFG_RATE_C:  mdl_c = val[39:0];
            srs_pkg::CFG_RATE_D:  mdl_d = val[31:0];
            srs_pkg::CFG_INIT_X1: mdl_init1 = val[23:0];
            srs_pkg::CFG_INIT_X2: mdl_init2 = val[23:0];
            default: ;
        endcase
    endtask

    task automatic load_all(logic [39:0] a, logic [39:0] b, logic [39:0] c, logic [39:0] d,
                            logic [39:0] x1, logic [39:0] x2);
        write_reg(srs_pkg::CFG_RATE_A, a);
        write_reg(srs_pkg::CFG_RATE_B, b);
        write_reg(srs_pkg::CFG_RATE_C, c);
        write_reg(srs_pkg::CFG_RATE_D, d);
        write_reg(srs_pkg::CFG_INIT_X1, x1);
        write_reg(srs_pkg::CFG_INIT_X2, x2);
    endtask

    function automatic logic [31:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [39:0] pick_reg_value(int bits);
        logic [39:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = 40'($urandom_range(1, 1 << 18));
            default: v = 40'({$urandom, $urandom});
        endcase
        // upper garbage beyond the register width is also driven sometimes
        return ($urandom_range(0, 3) == 0) ? v : (v & ((40'd1 << bits) - 40'd1));
    endfunction

    // all registers zero after reset: every step reports a zero total rate
    task automatic test_zero_rate_after_reset();
        send_item(OPC_STEP, 32'h1234_5678, 32'h8000_0000);
        send_item(OPC_RESTART, '0, '0);
        send_item(OPC_STEP, 32'd0, 32'hFFFF_FFFF);
    endtask

    // field extremes, zero u_wait, saturated counts and rates
    task automatic test_directed_cases();
        load_all(40'h1_0000, 40'h8000, 40'h100, 40'h4000, 40'd10, 40'd5);
        send_item(OPC_RESTART, '1, '1);
        send_item(OPC_STEP, 32'd0, 32'd0);
        send_item(OPC_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OPC_STEP, 32'd1, 32'h4000_0000);
        send_item(OPC_STEP, 32'h8000_0000, 32'hC000_0000);
        // only inflow: x1 at its top stays there
        load_all(40'h1, 40'h0, 40'h0, 40'h0, 40'hFF_FFFF, 40'h0);
        send_item(OPC_RESTART, '0, '0);
        send_item(OPC_STEP, 32'h0000_0001, 32'h7FFF_FFFF);
        // conversion only: x2 at its top stays there
        load_all(40'h0, 40'hFFFF_FFFF, 40'h0, 40'h0, 40'h3, 40'hFF_FFFF);
        send_item(OPC_RESTART, '0, '0);
        send_item(OPC_STEP, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_item(OPC_STEP, 32'h0000_0100, 32'h8000_0000);
        // every register at its maximum: the cubic rate and the first rate saturate
        load_all('1, '1, '1, '1, '1, '1);
        send_item(OPC_RESTART, '0, '0);
        send_item(OPC_STEP, 32'h0000_0001, 32'd0);
        send_item(OPC_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OPC_STEP, 32'h5555_5555, 32'hAAAA_AAAA);
        // indexes past the register list are ignored
        write_reg(3'd6, '1);
        write_reg(3'd7, 40'h12_3456);
        send_item(OPC_STEP, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    endtask

    // random phases, each with its own register setting
    task automatic test_random_walks();
        int n;
        for (int ph = 0; ph < 12; ph++) begin
            idle_free = (ph % 4 == 3);
            load_all(pick_reg_value(32), pick_reg_value(32), pick_reg_value(40),
                     pick_reg_value(32),
                     ($urandom_range(0, 1) != 0) ? 40'($urandom_range(0, 40)) : pick_reg_value(24),
                     ($urandom_range(0, 1) != 0) ? 40'($urandom_range(0, 40)) : pick_reg_value(24));
            send_item(OPC_RESTART, $urandom, $urandom);
            n = $urandom_range(80, 120);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OPC_RESTART, $urandom, $urandom);
                else
                    send_item(OPC_STEP, pick_fraction(), pick_fraction());
            end
        end
        idle_free = 1'b0;
    endtask

    // result side: stall pattern with calm stretches
    int stall_phase;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (idle_free || stall_phase[8:7] == 2'b00)
            i_m_tready <= 1'b1;
        else
            i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_step_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[23:0] !== want.x1) begin
                    $error("count_x1 exp %0h got %0h", want.x1, o_m_tdata[23:0]);
                    errors++;
                end
                if (o_m_tdata[47:24] !== want.x2) begin
                    $error("count_x2 exp %0h got %0h", want.x2, o_m_tdata[47:24]);
                    errors++;
                end
                if (o_m_tdata[111:48] !== want.elapsed) begin
                    $error("elapsed_time exp %0h got %0h", want.elapsed, o_m_tdata[111:48]);
                    errors++;
                end
                if (o_m_tdata[113:112] !== want.reac) begin
                    $error("reaction exp %0h got %0h", want.reac, o_m_tdata[113:112]);
                    errors++;
                end
                if (o_m_tuser !== want.zero) begin
                    $error("rate_zero exp %0h got %0h", want.zero, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        idle_free = 1'b0;
        burst_left = 0;
        stall_phase = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        {mdl_a, mdl_b, mdl_d, mdl_c, mdl_init1, mdl_init2} = '0;
        {mdl_x1, mdl_x2, mdl_time} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_zero_rate_after_reset();
        test_directed_cases();
        test_random_walks();

        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: stochastic_reaction_step.f
src/srs_pkg.sv
src/srs_div.sv
src/srs_ctrl.sv
src/srs_dpath.sv
src/stochastic_reaction_step.sv
tb/tb_top.sv
